### hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the ray/sphere intersection block
// Payload structs, configuration register indexes and the internal word
// widths of the exact integer datapath.
// ----------------------------------------------------------------------------
package rsi_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTRE_X = 2'd0,
		CFG_CENTRE_Y = 2'd1,
		CFG_CENTRE_Z = 2'd2,
		CFG_RADIUS   = 2'd3
	} cfg_idx_t;

	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int DIST_W   = 32;

	// Datapath widths (integer LSB units, exact)
	localparam int E_W    = 33;   // origin minus centre
	localparam int DOT_W  = 67;   // dot(dir, e), signed
	localparam int DM_W   = 65;   // |dot|
	localparam int N2_W   = 64;   // |dir|^2
	localparam int EE_W   = 66;   // |e|^2
	localparam int R2_W   = 62;   // r^2
	localparam int C_W    = 67;   // |e|^2 - r^2, signed
	localparam int CM_W   = 66;   // c when positive
	localparam int CN2_W  = CM_W + N2_W;   // c * |dir|^2
	localparam int DOT2_W = DM_W + DM_W;   // dot^2
	localparam int A0_W   = CM_W + CN2_W;  // c^2 * |dir|^2
	localparam int PW     = 204;  // quartic evaluator word, signed
	localparam int QW     = 134;  // quadratic evaluator word, signed
	localparam int MUL_DIGIT_W = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] cam_x;
		logic signed [COORD_W-1:0] cam_y;
		logic signed [COORD_W-1:0] cam_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
		logic signed [COORD_W-1:0] centre_z;
		logic [RADIUS_W-1:0]       sphere_radius;
	} cfg_t;

	// Front end result: magnitudes and the early hit qualifier
	typedef struct packed {
		logic             ok;
		logic [DM_W-1:0]  dm;
		logic [CM_W-1:0]  cm;
		logic [N2_W-1:0]  n2;
	} front_t;

	typedef struct packed {
		logic              ok;
		logic [CN2_W-1:0]  cn2;
		logic [CM_W-1:0]   cm;
		logic [N2_W-1:0]   n2;
	} m2_side_t;

	typedef struct packed {
		logic               ok;
		logic [DOT2_W-1:0]  dot2;
		logic [CN2_W-1:0]   cn2;
		logic [N2_W-1:0]    n2;
	} m3_side_t;

	typedef struct packed {
		logic               ok;
		logic [N2_W-1:0]    n2;
		logic [DOT2_W-1:0]  dot2;
		logic [CN2_W-1:0]   cn2;
		logic [A0_W-1:0]    a0;
	} root_in_t;

endpackage

### hdl/rsi_mul.sv
// ----------------------------------------------------------------------------
// rsi_mul: pipelined unsigned multiplier with sideband
// One DW-bit digit of b per stage; the sideband rides along with the product.
// ----------------------------------------------------------------------------
module rsi_mul #(
	parameter int AW = 66,
	parameter int BW = 64,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [AW+BW-1:0] p,
	output logic [SW-1:0] side_out
);

	localparam int NS = (BW + DW - 1) / DW;
	localparam int BP = NS * DW;
	localparam int PW = AW + BW;

	logic [NS-1:0] v_s;
	logic [AW-1:0] a_s    [NS];
	logic [BP-1:0] b_s    [NS];
	logic [PW-1:0] acc_s  [NS];
	logic [SW-1:0] side_s [NS];
	logic [NS:0]   rdy;

	assign rdy[NS] = out_ready;

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic [AW-1:0]    a_src;
		logic [BP-1:0]    b_src;
		logic [PW-1:0]    acc_src;
		logic [SW-1:0]    side_src;
		logic             v_src;
		logic [AW+DW-1:0] pp;

		if (g == 0) begin : g_first
			assign a_src    = a;
			assign b_src    = BP'(b);
			assign acc_src  = '0;
			assign side_src = side_in;
			assign v_src    = in_valid;
		end else begin : g_next
			assign a_src    = a_s[g-1];
			assign b_src    = b_s[g-1];
			assign acc_src  = acc_s[g-1];
			assign side_src = side_s[g-1];
			assign v_src    = v_s[g-1];
		end

		assign pp     = (AW+DW)'(a_src) * (AW+DW)'(b_src[g*DW +: DW]);
		assign rdy[g] = ~v_s[g] | rdy[g+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				v_s[g] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && v_src) begin
				a_s[g]    <= a_src;
				b_s[g]    <= b_src;
				acc_s[g]  <= acc_src + (PW'(pp) << (g*DW));
				side_s[g] <= side_src;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[NS-1];
	assign p         = acc_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

### hdl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front: vector front end
// Offset from the centre, per-axis products, sums, and the early miss tests.
// ----------------------------------------------------------------------------
module rsi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  rsi_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  rsi_pkg::ray_t     ray,
	output logic              out_valid,
	input  logic              out_ready,
	output rsi_pkg::front_t   dout
);

	localparam int CW = rsi_pkg::COORD_W;
	localparam int EW = rsi_pkg::E_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic r1, r2, r3, r4;

	logic signed [CW-1:0] cam  [3];
	logic signed [CW-1:0] dir  [3];
	logic signed [CW-1:0] ctr  [3];

	logic signed [EW-1:0]       e_s1 [3];
	logic signed [CW-1:0]       d_s1 [3];
	logic [rsi_pkg::RADIUS_W-1:0] r_s1;

	logic signed [CW+EW-1:0]    pde_s2 [3];
	logic [2*CW-2:0]            pdd_s2 [3];
	logic [2*EW-2:0]            pee_s2 [3];
	logic [rsi_pkg::R2_W-1:0]   r2_s2;

	logic signed [rsi_pkg::DOT_W-1:0] dot_s3;
	logic [rsi_pkg::N2_W-1:0]         n2_s3;
	logic [rsi_pkg::EE_W-1:0]         ee_s3;
	logic [rsi_pkg::R2_W-1:0]         r2_s3;

	logic signed [rsi_pkg::C_W-1:0]   c_w;
	logic signed [rsi_pkg::DOT_W-1:0] ndot_w;

	always_comb begin
		cam[0] = ray.cam_x;  cam[1] = ray.cam_y;  cam[2] = ray.cam_z;
		dir[0] = ray.dir_x;  dir[1] = ray.dir_y;  dir[2] = ray.dir_z;
		ctr[0] = cfg.centre_x;  ctr[1] = cfg.centre_y;  ctr[2] = cfg.centre_z;
	end

	// Bubble-collapsing stall chain
	assign r4       = ~v_s4 | out_ready;
	assign r3       = ~v_s3 | r4;
	assign r2       = ~v_s2 | r3;
	assign r1       = ~v_s1 | r2;
	assign in_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i] <= EW'(cam[i]) - EW'(ctr[i]);
				d_s1[i] <= dir[i];
			end
			r_s1 <= cfg.sphere_radius;
		end
	end

	always_ff @(posedge clk) begin
		if (r2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				pde_s2[i] <= (CW+EW)'(d_s1[i]) * (CW+EW)'(e_s1[i]);
				pdd_s2[i] <= (2*CW-1)'((2*CW)'(d_s1[i]) * (2*CW)'(d_s1[i]));
				pee_s2[i] <= (2*EW-1)'((2*EW)'(e_s1[i]) * (2*EW)'(e_s1[i]));
			end
			r2_s2 <= rsi_pkg::R2_W'(r_s1) * rsi_pkg::R2_W'(r_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (r3 && v_s2) begin
			dot_s3 <= rsi_pkg::DOT_W'(pde_s2[0]) + rsi_pkg::DOT_W'(pde_s2[1])
				+ rsi_pkg::DOT_W'(pde_s2[2]);
			n2_s3  <= rsi_pkg::N2_W'(pdd_s2[0]) + rsi_pkg::N2_W'(pdd_s2[1])
				+ rsi_pkg::N2_W'(pdd_s2[2]);
			ee_s3  <= rsi_pkg::EE_W'(pee_s2[0]) + rsi_pkg::EE_W'(pee_s2[1])
				+ rsi_pkg::EE_W'(pee_s2[2]);
			r2_s3  <= r2_s2;
		end
	end

	assign c_w    = signed'(rsi_pkg::C_W'(ee_s3)) - signed'(rsi_pkg::C_W'(r2_s3));
	assign ndot_w = -dot_s3;

	// Hit needs a nonzero direction, the sphere ahead and the origin outside
	always_ff @(posedge clk) begin
		if (r4 && v_s3) begin
			dout.ok <= (n2_s3 != '0) && dot_s3[rsi_pkg::DOT_W-1]
				&& !c_w[rsi_pkg::C_W-1] && (c_w != '0);
			dout.dm <= ndot_w[rsi_pkg::DM_W-1:0];
			dout.cm <= c_w[rsi_pkg::CM_W-1:0];
			dout.n2 <= n2_s3;
		end
	end

	assign out_valid = v_s4;

endmodule

### hdl/rsi_root.sv
// ----------------------------------------------------------------------------
// rsi_root: nearer-root bit search
// Setup stage then one stage per result bit; polynomials are stepped by
// finite differences so each stage needs only shifts and adds.
// ----------------------------------------------------------------------------
module rsi_root (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsi_pkg::root_in_t   din,
	output logic                out_valid,
	input  logic                out_ready,
	output rsi_pkg::res_t       dout
);

	localparam int PW = rsi_pkg::PW;
	localparam int QW = rsi_pkg::QW;
	localparam int NB = rsi_pkg::DIST_W;
	localparam int NST = NB + 1;

	// P(k) = n2 k^4 + (2 c n2 - 4 dot^2) k^2 + c^2 n2, must stay >= 0
	// Q(k) = dot^2 - n2 k^2, must stay >= 0 (k at or below the vertex)
	logic [NST-1:0]                 v_s;
	logic [NST-1:0]                 hit_s;
	logic [NB-1:0]                  k_s  [NST];
	logic [rsi_pkg::N2_W-1:0]       a4_s [NST];
	logic signed [PW-1:0]           p0_s [NST];
	logic signed [PW-1:0]           p1_s [NST];
	logic signed [PW-1:0]           p2_s [NST];
	logic signed [PW-1:0]           p3_s [NST];
	logic signed [QW-1:0]           q0_s [NST];
	logic signed [QW-1:0]           q1_s [NST];
	logic [NST:0]                   rdy;

	assign rdy[NST] = out_ready;
	for (genvar g = 0; g < NST; g++) begin : g_rdy
		assign rdy[g] = ~v_s[g] | rdy[g+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			hit_s[0] <= din.ok && (din.dot2 > din.cn2);
			k_s[0]   <= '0;
			a4_s[0]  <= din.n2;
			p0_s[0]  <= signed'(PW'(din.a0));
			p1_s[0]  <= '0;
			p2_s[0]  <= signed'(PW'(din.cn2) << 1) - signed'(PW'(din.dot2) << 2);
			p3_s[0]  <= '0;
			q0_s[0]  <= signed'(QW'(din.dot2));
			q1_s[0]  <= '0;
		end
	end

	for (genvar g = 1; g < NST; g++) begin : g_bit
		localparam int SH = NB - g;
		logic signed [PW-1:0] a4x, pt, p1n, p2n, p3n;
		logic signed [QW-1:0] n2q, qt, q1n;
		logic                 take;

		assign a4x = signed'(PW'(a4_s[g-1]));
		assign n2q = signed'(QW'(a4_s[g-1]));
		assign pt  = p0_s[g-1] + (p1_s[g-1] <<< SH) + (p2_s[g-1] <<< (2*SH))
			+ (p3_s[g-1] <<< (3*SH)) + (a4x <<< (4*SH));
		assign qt  = q0_s[g-1] + (q1_s[g-1] <<< SH) - (n2q <<< (2*SH));
		assign take = ~pt[PW-1] & ~qt[QW-1];
		assign p1n = p1_s[g-1] + (p2_s[g-1] <<< (SH+1)) + (p3_s[g-1] <<< (2*SH))
			+ (p3_s[g-1] <<< (2*SH+1)) + (a4x <<< (3*SH+2));
		assign p2n = p2_s[g-1] + (p3_s[g-1] <<< SH) + (p3_s[g-1] <<< (SH+1))
			+ (a4x <<< (2*SH+1)) + (a4x <<< (2*SH+2));
		assign p3n = p3_s[g-1] + (a4x <<< (SH+2));
		assign q1n = q1_s[g-1] - (n2q <<< (SH+1));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				v_s[g] <= v_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && v_s[g-1]) begin
				hit_s[g] <= hit_s[g-1];
				a4_s[g]  <= a4_s[g-1];
				if (take) begin
					k_s[g]  <= k_s[g-1] | (NB'(1) << SH);
					p0_s[g] <= pt;
					p1_s[g] <= p1n;
					p2_s[g] <= p2n;
					p3_s[g] <= p3n;
					q0_s[g] <= qt;
					q1_s[g] <= q1n;
				end else begin
					k_s[g]  <= k_s[g-1];
					p0_s[g] <= p0_s[g-1];
					p1_s[g] <= p1_s[g-1];
					p2_s[g] <= p2_s[g-1];
					p3_s[g] <= p3_s[g-1];
					q0_s[g] <= q0_s[g-1];
					q1_s[g] <= q1_s[g-1];
				end
			end
		end
	end

	assign in_ready      = rdy[0];
	assign out_valid     = v_s[NST-1];
	assign dout.hit      = hit_s[NST-1];
	assign dout.distance = hit_s[NST-1] ? k_s[NST-1] : '0;

endmodule

### hdl/ray_sphere_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection_top: streaming ray against sphere hit test
// One ray in, one hit flag and nearer distance out, exact integer math.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake          payload
//  ray          in   ray_valid/ready    rsi_pkg::ray_t (origin, direction)
//  res          out  res_valid/ready    rsi_pkg::res_t (hit, distance)
//  cfg          in   cfg_wen            cfg_idx, cfg_wdata (no read-back)
//
//  Throughput is one ray per cycle while results are taken. The stages are
//  the front end, the three digit-serial multipliers (16-bit digits, one
//  digit per stage) and the root search (setup plus one stage per distance bit).
//  Every stage holds a valid bit and advances when the next one is empty or
//  moving, so bubbles collapse and a stalled result does not block input
//  until all stages are full. Reset clears the valid bits and loads the
//  default sphere (centre at origin, radius 1.0).
//
module ray_sphere_intersection_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ray_valid,
	output logic                             ray_ready,
	input  rsi_pkg::ray_t                    ray,
	output logic                             res_valid,
	input  logic                             res_ready,
	output rsi_pkg::res_t                    res,
	input  logic                             cfg_wen,
	input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rsi_pkg::COORD_W-1:0]      cfg_wdata
);

	rsi_pkg::cfg_t     cfg_q;
	rsi_pkg::front_t   front;
	rsi_pkg::front_t   side1;
	rsi_pkg::m2_side_t side2_in, side2;
	rsi_pkg::m3_side_t side3_in, side3;
	rsi_pkg::root_in_t root_in;

	logic front_valid, front_ready;
	logic m1_valid, m1_ready;
	logic m2_valid, m2_ready;
	logic m3_valid, m3_ready;

	logic [rsi_pkg::CN2_W-1:0]  cn2;
	logic [rsi_pkg::DOT2_W-1:0] dot2;
	logic [rsi_pkg::A0_W-1:0]   a0;

	// Configuration registers: take a write whenever the enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x      <= '0;
			cfg_q.centre_y      <= '0;
			cfg_q.centre_z      <= '0;
			cfg_q.sphere_radius <= rsi_pkg::RADIUS_W'(1) << FRAC_BITS;
		end else if (cfg_wen) begin
			unique case (rsi_pkg::cfg_idx_t'(cfg_idx))
				rsi_pkg::CFG_CENTRE_X: cfg_q.centre_x      <= cfg_wdata;
				rsi_pkg::CFG_CENTRE_Y: cfg_q.centre_y      <= cfg_wdata;
				rsi_pkg::CFG_CENTRE_Z: cfg_q.centre_z      <= cfg_wdata;
				rsi_pkg::CFG_RADIUS:   cfg_q.sphere_radius <= cfg_wdata[rsi_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Offset, per-axis products and the early miss tests
	rsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (ray_valid),
		.in_ready  (ray_ready),
		.ray       (ray),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.dout      (front)
	);

	// c * |dir|^2
	rsi_mul #(
		.AW (rsi_pkg::CM_W),
		.BW (rsi_pkg::N2_W),
		.DW (rsi_pkg::MUL_DIGIT_W),
		.SW ($bits(rsi_pkg::front_t))
	) u_mul_cn2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.a         (front.cm),
		.b         (front.n2),
		.side_in   (front),
		.out_valid (m1_valid),
		.out_ready (m1_ready),
		.p         (cn2),
		.side_out  (side1)
	);

	always_comb begin
		side2_in.ok  = side1.ok;
		side2_in.cn2 = cn2;
		side2_in.cm  = side1.cm;
		side2_in.n2  = side1.n2;
	end

	// dot^2
	rsi_mul #(
		.AW (rsi_pkg::DM_W),
		.BW (rsi_pkg::DM_W),
		.DW (rsi_pkg::MUL_DIGIT_W),
		.SW ($bits(rsi_pkg::m2_side_t))
	) u_mul_dot2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m1_valid),
		.in_ready  (m1_ready),
		.a         (side1.dm),
		.b         (side1.dm),
		.side_in   (side2_in),
		.out_valid (m2_valid),
		.out_ready (m2_ready),
		.p         (dot2),
		.side_out  (side2)
	);

	always_comb begin
		side3_in.ok   = side2.ok;
		side3_in.dot2 = dot2;
		side3_in.cn2  = side2.cn2;
		side3_in.n2   = side2.n2;
	end

	// c^2 * |dir|^2, the constant term of the root polynomial
	rsi_mul #(
		.AW (rsi_pkg::CM_W),
		.BW (rsi_pkg::CN2_W),
		.DW (rsi_pkg::MUL_DIGIT_W),
		.SW ($bits(rsi_pkg::m3_side_t))
	) u_mul_a0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m2_valid),
		.in_ready  (m2_ready),
		.a         (side2.cm),
		.b         (side2.cn2),
		.side_in   (side3_in),
		.out_valid (m3_valid),
		.out_ready (m3_ready),
		.p         (a0),
		.side_out  (side3)
	);

	always_comb begin
		root_in.ok   = side3.ok;
		root_in.n2   = side3.n2;
		root_in.dot2 = side3.dot2;
		root_in.cn2  = side3.cn2;
		root_in.a0   = a0;
	end

	// Final hit decision and floor of the nearer root, bit by bit
	rsi_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m3_valid),
		.in_ready  (m3_ready),
		.din       (root_in),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.dout      (res)
	);

	// A miss always carries a zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.distance == '0)
		else $error("miss with nonzero distance");

	// Input held off only when every stage is full, so the output is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ray_ready |-> res_valid && m3_valid && m2_valid && m1_valid && front_valid)
		else $error("input stalled with an empty stage");

	// A radius write lands in the register on the next edge
	a_radius_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen && cfg_idx == rsi_pkg::CFG_RADIUS
		|=> cfg_q.sphere_radius == $past(cfg_wdata[rsi_pkg::RADIUS_W-1:0]))
		else $error("radius write lost");

endmodule
